// ===== src/station_auth_assoc_table_top_defines.svh =====
// Assertion macros for the station table block.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef STATION_AUTH_ASSOC_TABLE_TOP_DEFINES_SVH
`define STATION_AUTH_ASSOC_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SAT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAT_ASSERT(label, clk, rst_n, prop, msg)
`define SAT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/sat_pkg.sv =====
// Shared types and constants for the station table block.
// No dependencies; imported by every module of the block.
`default_nettype none
package sat_pkg;

    localparam int STATIONS  = 16;
    localparam int IDX_W     = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATIONS - 1);

    localparam int ADDR_W    = 48;
    localparam int SEQ_W     = 16;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int MCAST_BIT = 40;

    localparam logic [SEQ_W-1:0] SEQ_ONE  = SEQ_W'(1);
    localparam logic [SEQ_W-1:0] SEQ_STEP = SEQ_W'(2);
    localparam logic [SEQ_W-1:0] SEQ_MAX  = '1;
    localparam logic [SEQ_W:0]   STEPS_TWO  = (SEQ_W + 1)'(2);
    localparam logic [SEQ_W:0]   STEPS_FOUR = (SEQ_W + 1)'(4);

    typedef enum logic [KIND_W-1:0] {
        K_AUTH, K_DEAUTH, K_ASSOC, K_REASSOC,
        K_DISASSOC, K_DATA_STA, K_DATA_UP, K_EXT_DISASSOC
    } t_kind;

    typedef enum logic [3:0] {
        A_NONE, A_AUTH_OK, A_AUTH_OOS, A_REJECT, A_ASSOC_RESP, A_REASSOC_RESP,
        A_DISTRIBUTE, A_UPPER, A_UPPER_DIST, A_SEND_DOWN, A_DROP
    } t_action;

    typedef enum logic [1:0] {N_NONE, N_ASSOC, N_DISASSOC} t_notify;

    typedef enum logic [1:0] {ST_NOAUTH, ST_AUTH, ST_ASSOC} t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTH_FOUR_STEPS, CFG_CONNECTED_TO_UPPER
    } t_cfg_reg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [SEQ_W-1:0]  exp_seq;
    } t_entry;

    typedef struct packed {
        logic   hit;
        logic   free_ok;
        t_entry entry;
    } t_lookup;

    typedef struct packed {
        t_action           action;
        t_notify           notify;
        logic [SEQ_W-1:0]  rseq;
        logic              rlast;
        logic              full;
        logic [ADDR_W-1:0] peer;
        logic              we;
        t_entry            wdata;
    } t_decision;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== src/sat_decide.sv =====
// Decision logic: reply action, notification and entry update for one event.
// Depends on sat_pkg.
`default_nettype none
module sat_decide
    import sat_pkg::*;
(
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [ADDR_W-1:0] i_sta,
    input  wire logic [ADDR_W-1:0] i_tgt,
    input  wire logic [SEQ_W-1:0]  i_seq,
    input  wire logic              i_to_ds,
    input  wire logic              i_four_steps,
    input  wire logic              i_upper,
    input  wire t_lookup           i_lookup,
    output t_decision              o_dec
);

    always_comb begin
        t_status          st;
        logic [SEQ_W-1:0] exp_seq;
        logic [SEQ_W:0]   seq_inc;
        logic [SEQ_W:0]   steps;
        logic             mcast;
        logic             assoc;

        st      = i_lookup.entry.status;
        exp_seq = i_lookup.entry.exp_seq;
        seq_inc = {1'b0, i_seq} + (SEQ_W + 1)'(1);
        steps   = i_four_steps ? STEPS_FOUR : STEPS_TWO;
        mcast   = i_tgt[MCAST_BIT];
        assoc   = i_lookup.hit && (i_lookup.entry.status == ST_ASSOC);

        o_dec        = '0;
        o_dec.action = A_NONE;
        o_dec.notify = N_NONE;
        o_dec.wdata  = i_lookup.entry;
        o_dec.peer   = (i_kind >= K_DATA_STA) ? i_tgt : i_sta;

        unique case (t_kind'(i_kind))
            K_AUTH: begin
                if (!i_lookup.hit && !i_lookup.free_ok) begin
                    o_dec.action = A_DROP;
                    o_dec.full   = 1'b1;
                end else begin
                    if (!i_lookup.hit) begin
                        st      = ST_NOAUTH;
                        exp_seq = SEQ_ONE;
                    end
                    if (i_seq == SEQ_ONE) begin
                        if (st == ST_ASSOC) begin
                            o_dec.notify = N_DISASSOC;
                        end
                        st      = ST_NOAUTH;
                        exp_seq = SEQ_ONE;
                    end
                    if (i_seq != exp_seq) begin
                        o_dec.action = A_AUTH_OOS;
                        exp_seq      = SEQ_ONE;
                    end else begin
                        o_dec.action = A_AUTH_OK;
                        o_dec.rseq   = seq_inc[SEQ_W] ? SEQ_MAX : seq_inc[SEQ_W-1:0];
                        if (seq_inc == steps) begin
                            o_dec.rlast = 1'b1;
                            if (st == ST_ASSOC) begin
                                o_dec.notify = N_DISASSOC;
                            end
                            st = ST_AUTH;
                        end else begin
                            exp_seq = exp_seq + SEQ_STEP;
                        end
                    end
                    o_dec.we            = 1'b1;
                    o_dec.wdata.addr    = i_sta;
                    o_dec.wdata.status  = st;
                    o_dec.wdata.exp_seq = exp_seq;
                end
            end
            K_DEAUTH: begin
                if (i_lookup.hit) begin
                    if (assoc) begin
                        o_dec.notify = N_DISASSOC;
                    end
                    o_dec.we            = 1'b1;
                    o_dec.wdata.status  = ST_NOAUTH;
                    o_dec.wdata.exp_seq = SEQ_ONE;
                end
            end
            K_ASSOC, K_REASSOC: begin
                if (!i_lookup.hit || i_lookup.entry.status == ST_NOAUTH) begin
                    o_dec.action = A_REJECT;
                end else begin
                    if (i_kind == K_ASSOC && !assoc) begin
                        o_dec.notify = N_ASSOC;
                    end
                    o_dec.action       = (i_kind == K_ASSOC) ? A_ASSOC_RESP : A_REASSOC_RESP;
                    o_dec.we           = 1'b1;
                    o_dec.wdata.status = ST_ASSOC;
                end
            end
            K_DISASSOC: begin
                if (i_lookup.hit) begin
                    if (assoc) begin
                        o_dec.notify = N_DISASSOC;
                    end
                    o_dec.we           = 1'b1;
                    o_dec.wdata.status = ST_AUTH;
                end
            end
            K_DATA_STA: begin
                if (!i_to_ds) begin
                    o_dec.action = A_DROP;
                end else if (mcast) begin
                    o_dec.action = i_upper ? A_UPPER_DIST : A_DISTRIBUTE;
                end else if (!i_lookup.hit) begin
                    o_dec.action = i_upper ? A_UPPER : A_DROP;
                end else begin
                    o_dec.action = assoc ? A_DISTRIBUTE : A_DROP;
                end
            end
            K_DATA_UP: begin
                o_dec.action = (mcast || assoc) ? A_SEND_DOWN : A_DROP;
            end
            K_EXT_DISASSOC: begin
                if (i_lookup.hit) begin
                    o_dec.we           = 1'b1;
                    o_dec.wdata.status = ST_NOAUTH;
                end
            end
            default: begin
                o_dec.action = A_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/sat_entry_mem.sv =====
// Station entry memory: one write port, one read port, registered read data.
// Depends on sat_pkg.
`default_nettype none
module sat_entry_mem
    import sat_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_entry        o_rdata
);

    t_entry r_mem [STATIONS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/sat_ctrl.sv =====
// Sequencer: table search, valid bits, configuration and result registers.
// Depends on sat_pkg, sat_decide and the assertion macro header.
`default_nettype none
`include "station_auth_assoc_table_top_defines.svh"
module sat_ctrl
    import sat_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [ADDR_W-1:0] i_station_address,
    input  wire logic [ADDR_W-1:0] i_target_address,
    input  wire logic [SEQ_W-1:0]  i_auth_seq,
    input  wire logic              i_to_ds,
    input  wire logic              i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic              i_cfg_data,
    output t_mem_req               o_mem_req,
    input  wire t_entry            i_mem_rdata,
    output logic                   o_strobe,
    output logic [3:0]             o_action,
    output logic [1:0]             o_notify,
    output logic [SEQ_W-1:0]       o_response_seq,
    output logic                   o_response_last,
    output logic [ADDR_W-1:0]      o_peer_address,
    output logic                   o_table_full
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} t_state;

    t_state            r_state;
    logic [STATIONS-1:0] r_valid;
    logic [IDX_W-1:0]  r_idx;
    logic              r_issue_done;
    logic              r_chk;
    logic [IDX_W-1:0]  r_chk_idx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_ent_idx;
    logic              r_free_ok;
    logic [IDX_W-1:0]  r_free_idx;
    t_entry            r_entry;
    logic              r_four_steps;
    logic              r_upper;
    logic [KIND_W-1:0] r_kind;
    logic [ADDR_W-1:0] r_sta;
    logic [ADDR_W-1:0] r_tgt;
    logic [SEQ_W-1:0]  r_seq;
    logic              r_to_ds;
    logic              r_strobe;
    t_action           r_action;
    t_notify           r_notify;
    logic [SEQ_W-1:0]  r_rseq;
    logic              r_rlast;
    logic [ADDR_W-1:0] r_peer;
    logic              r_full;

    logic [ADDR_W-1:0] w_key;
    logic              w_match;
    logic [IDX_W-1:0]  w_waddr;
    t_lookup           w_lookup;
    t_decision         w_dec;

    assign w_key    = (r_kind >= K_DATA_STA) ? r_tgt : r_sta;
    assign w_match  = r_chk && r_valid[r_chk_idx] && (i_mem_rdata.addr == w_key);
    assign w_waddr  = r_hit ? r_ent_idx : r_free_idx;
    assign w_lookup = '{hit: r_hit, free_ok: r_free_ok, entry: r_entry};

    sat_decide u_decide (
        .i_kind       (r_kind),
        .i_sta        (r_sta),
        .i_tgt        (r_tgt),
        .i_seq        (r_seq),
        .i_to_ds      (r_to_ds),
        .i_four_steps (r_four_steps),
        .i_upper      (r_upper),
        .i_lookup     (w_lookup),
        .o_dec        (w_dec)
    );

    always_comb begin
        o_mem_req       = '0;
        o_mem_req.re    = (r_state == S_SCAN) && !r_issue_done;
        o_mem_req.raddr = r_idx;
        o_mem_req.we    = (r_state == S_UPDATE) && w_dec.we;
        o_mem_req.waddr = w_waddr;
        o_mem_req.wdata = w_dec.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_strobe     <= 1'b0;
            r_four_steps <= 1'b1;
            r_upper      <= 1'b1;
            r_issue_done <= 1'b0;
            r_chk        <= 1'b0;
            r_hit        <= 1'b0;
            r_free_ok    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && i_cfg_index == CFG_AUTH_FOUR_STEPS) begin
                r_four_steps <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_CONNECTED_TO_UPPER) begin
                r_upper <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind       <= i_kind;
                        r_sta        <= i_station_address;
                        r_tgt        <= i_target_address;
                        r_seq        <= i_auth_seq;
                        r_to_ds      <= i_to_ds;
                        r_idx        <= '0;
                        r_issue_done <= 1'b0;
                        r_chk        <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free_ok    <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle, compare the previous one
                    if (!r_issue_done) begin
                        r_chk     <= 1'b1;
                        r_chk_idx <= r_idx;
                        if (!r_valid[r_idx] && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_idx;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end else begin
                        r_chk <= 1'b0;
                    end
                    if (w_match) begin
                        r_hit     <= 1'b1;
                        r_ent_idx <= r_chk_idx;
                        r_entry   <= i_mem_rdata;
                        r_state   <= S_UPDATE;
                    end else if (r_chk && r_chk_idx == LAST_IDX) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (w_dec.we) begin
                        r_valid[w_waddr] <= 1'b1;
                    end
                    r_action <= w_dec.action;
                    r_notify <= w_dec.notify;
                    r_rseq   <= w_dec.rseq;
                    r_rlast  <= w_dec.rlast;
                    r_peer   <= w_dec.peer;
                    r_full   <= w_dec.full;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_action        = r_action;
    assign o_notify        = r_notify;
    assign o_response_seq  = r_rseq;
    assign o_response_last = r_rlast;
    assign o_peer_address  = r_peer;
    assign o_table_full    = r_full;

    `SAT_ASSERT(a_accept_goes_busy, i_clk, i_rst_n, (i_start && !o_busy) |=> o_busy, "accepted transaction did not start a search")
    `SAT_ASSERT_ALWAYS(a_result_when_idle, i_clk, r_strobe |-> (r_state == S_IDLE), "result strobe outside idle")
    `SAT_ASSERT(a_full_means_drop, i_clk, i_rst_n, (r_strobe && r_full) |-> (r_action == A_DROP), "table full without drop")
    `SAT_ASSERT(a_write_only_in_update, i_clk, i_rst_n, o_mem_req.we |-> ((r_state == S_UPDATE) && (r_hit || r_free_ok)), "entry write without a target entry")

endmodule
`default_nettype wire

// ===== src/station_auth_assoc_table_top.sv =====
// Top level of the access-point station table.
// Depends on sat_pkg, sat_ctrl and sat_entry_mem.
//
// Channel   Direction  Handshake                  Payload
// command   in         start / busy               kind, station/target address, auth_seq, to_ds
// result    out        o_result_strobe (1 cycle)  action, notify, response seq/last, peer, full
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item's search ends at the first valid entry that matches its key, or after
// the last entry (STATIONS - 1) when it matches none; the search reads one entry
// a cycle through the single read port of the table memory, then updates.
// busy drops in the cycle that the result is shown, so a new item may start then.
// Reset is synchronous: all entries become free, both registers return to 1.
// The receiver takes each result in its strobe cycle and cannot stall.
`default_nettype none
module station_auth_assoc_table_top
    import sat_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [ADDR_W-1:0]    i_station_address,
    input  wire logic [ADDR_W-1:0]    i_target_address,
    input  wire logic [SEQ_W-1:0]     i_auth_seq,
    input  wire logic                 i_to_ds,
    output logic                      o_result_strobe,
    output logic [3:0]                o_action,
    output logic [1:0]                o_notify,
    output logic [SEQ_W-1:0]          o_response_seq,
    output logic                      o_response_last,
    output logic [ADDR_W-1:0]         o_peer_address,
    output logic                      o_table_full,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                 i_cfg_data
);

    t_mem_req w_mem_req;
    t_entry   w_mem_rdata;

    assign o_cfg_ready = 1'b1;

    sat_entry_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    sat_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_kind            (i_kind),
        .i_station_address (i_station_address),
        .i_target_address  (i_target_address),
        .i_auth_seq        (i_auth_seq),
        .i_to_ds           (i_to_ds),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mem_req         (w_mem_req),
        .i_mem_rdata       (w_mem_rdata),
        .o_strobe          (o_result_strobe),
        .o_action          (o_action),
        .o_notify          (o_notify),
        .o_response_seq    (o_response_seq),
        .o_response_last   (o_response_last),
        .o_peer_address    (o_peer_address),
        .o_table_full      (o_table_full)
    );

endmodule
`default_nettype wire
